[rtl/core/gld_pkg.sv]
// Shared constants, types and helpers of the grid Laplacian blur detector.
package gld_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CELL_ROWS = 3;
  localparam int CELL_COLS = 3;
  localparam int CELLS = CELL_ROWS * CELL_COLS;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SIZE_W = 13;
  localparam int LS_DEPTH = 3 * MAX_WIDTH;
  localparam int LS_AW = $clog2(LS_DEPTH);
  localparam int CELL_W = $clog2(CELLS + 1);
  localparam int VAR_W = 29;
  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  localparam int SUM_W = 33;
  localparam int SQ_W = 42;
  localparam int CNT_W = 22;
  localparam int MC_W = SQ_W;
  localparam int ML_W = SUM_W;
  localparam int MP_W = MC_W + ML_W;
  localparam int DV_W = 2 * CNT_W;
  localparam int DD_W = MP_W + 8;
  localparam int REM_W = DV_W + 1;

  localparam logic [32:0] RECIP_R = 33'((64'd1 << 32) + CELL_ROWS - 1) / CELL_ROWS;
  localparam logic [32:0] RECIP_C = 33'((64'd1 << 32) + CELL_COLS - 1) / CELL_COLS;

  localparam logic [1:0] IDX_WIDTH = 2'd0;
  localparam logic [1:0] IDX_HEIGHT = 2'd1;
  localparam logic [1:0] IDX_THRESH = 2'd2;

  typedef enum logic [3:0] {
    ST_IN, ST_LAP, ST_V_RD, ST_V_LD, ST_V_MA, ST_V_MB, ST_V_MC, ST_V_DIV,
    ST_V_CMP, ST_R_SEED, ST_R_GROW, ST_R_SUM, ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0] sq;
    logic [CNT_W-1:0] cnt;
  } cell_t;

  // One step of 4-connected growth of a region inside the blurred map.
  function automatic logic [CELLS-1:0] grow(logic [CELLS-1:0] rg, logic [CELLS-1:0] map);
    logic [CELLS-1:0] nx;
    nx = rg;
    for (int c = 0; c < CELLS; c++) begin
      if (rg[c]) begin
        if (c / CELL_COLS > 0) nx[c - CELL_COLS] = 1'b1;
        if (c / CELL_COLS < CELL_ROWS - 1) nx[c + CELL_COLS] = 1'b1;
        if (c % CELL_COLS > 0) nx[c - 1] = 1'b1;
        if (c % CELL_COLS < CELL_COLS - 1) nx[c + 1] = 1'b1;
      end
    end
    return nx & map;
  endfunction

endpackage

[rtl/core/grid_laplacian_blur_detector_unit.sv]
// Top level of the grid Laplacian blur detector with line store and cell store.
//
// The block takes the 8-bit samples of one frame in raster order on the pixel
// channel (valid/ready) and gives one result transaction per frame on the
// result channel: the smallest cell variance, the largest blurred region and
// its flag. Frame size and threshold are to be set through the write port
// while idle; the block itself does not enforce this. Samples of a row are
// taken at one per cycle. At the end of each row from the second on, the
// Laplacian of the row before is swept out of the line store pixel by pixel,
// bound by its single read port; the pixel channel is not ready during that
// sweep. After the last row the final row is swept too, then each of the nine
// cells takes three serial multiplies and a serial division, and the region
// search runs over the blurred-cell map. The result register holds a result until it is
// taken while the next frame streams in; a frame end waits only if the earlier
// result is still pending. Reset clears the position counters and the cell
// store valid bits and loads the default size of 640 by 480 and threshold 100.0.
module grid_laplacian_blur_detector_unit import gld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [VAR_W-1:0] cfg_data_i,
  input  logic             pixel_valid_i,
  output logic             pixel_ready_o,
  input  logic [7:0]       pixel_i,
  output logic             result_valid_o,
  input  logic             result_ready_i,
  output logic [VAR_W-1:0] var_min_o,
  output logic [3:0]       largest_region_o,
  output logic             large_blur_area_o
);

  state_e st_q, st_d;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [VAR_W-1:0] thresh_q;
  logic [SIZE_W-1:0] rb_q [1:CELL_ROWS-1];
  logic [SIZE_W-1:0] cb_q [1:CELL_COLS-1];

  logic [COL_W-1:0] col_q, row_q, lx_q;
  logic [1:0] slot_q, up_q, ctr_q, dn_q;
  logic [CELL_W-1:0] gr_q;
  logic second_q, fin_q;
  logic [2:0] ph_q;
  logic [7:0] mem [0:LS_DEPTH-1];
  logic [7:0] rd_q;
  logic signed [11:0] acc_q, v_q;

  cell_t cmem [0:CELLS-1];
  cell_t cell_rd_q, ent, upd;
  logic cell_vld_q;
  logic [CELLS-1:0] cvalid_q;

  logic [CELL_W-1:0] vk_q, rk_q;
  logic [6:0] cnt_q;
  logic [CNT_W-1:0] n_q;
  logic [SUM_W-1:0] mag_q, mag;
  logic [MC_W-1:0] mcand_q;
  logic [MP_W-1:0] p_q, a_q, b_q, p_next;
  logic [MC_W:0] mt;
  logic [DV_W-1:0] dv_q;
  logic [DD_W-1:0] dd_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W:0] r2;
  logic ge;
  logic [VAR_W-1:0] q_q, minv_q, var_v;
  logic sat_q, z_q;
  logic [CELLS-1:0] map_q, seen_q, rg_q;
  logic [3:0] best_q, rsize;

  logic res_valid_q;
  logic [VAR_W-1:0] res_min_q;
  logic [3:0] res_reg_q;
  logic res_flag_q;

  logic acc_in, row_end, last_row, lap_end, mul_done, div_done, grow_done, size_wr;
  logic [SIZE_W-1:0] csz;
  logic [1:0] slot_m1, slot_p1;
  logic [CELL_W-1:0] gr_prev, gr_cur, gc, k_cur, cell_addr;
  logic [COL_W-1:0] lxl, lxr;
  logic [LS_AW-1:0] rd_addr, wr_addr;
  logic signed [11:0] rdx;
  logic signed [23:0] vsq;

  assign acc_in = pixel_valid_i && pixel_ready_o;
  assign row_end = acc_in && ({1'b0, col_q} + 13'd1 == width_q);
  assign last_row = ({1'b0, row_q} + 13'd1 >= height_q);
  assign lap_end = (st_q == ST_LAP) && (ph_q == 3'd6) && ({1'b0, lx_q} == width_q - 13'd1);
  assign mul_done = (cnt_q == 7'(ML_W - 1));
  assign div_done = (cnt_q == 7'(DD_W - 1));
  assign grow_done = (cnt_q == 7'(CELLS - 2));
  assign size_wr = cfg_we_i && (cfg_index_i == IDX_WIDTH || cfg_index_i == IDX_HEIGHT);

  assign slot_m1 = (slot_q == 2'd0) ? 2'd2 : slot_q - 2'd1;
  assign slot_p1 = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;

  always_comb begin
    gr_prev = '0;
    gr_cur = '0;
    gc = '0;
    for (int j = 1; j < CELL_ROWS; j++) begin
      if (rb_q[j] <= {1'b0, row_q - COL_W'(1)}) gr_prev = gr_prev + 1'b1;
      if (rb_q[j] <= {1'b0, row_q}) gr_cur = gr_cur + 1'b1;
    end
    for (int j = 1; j < CELL_COLS; j++) begin
      if (cb_q[j] <= {1'b0, lx_q}) gc = gc + 1'b1;
    end
    k_cur = CELL_W'(gr_q * CELL_COLS) + gc;
  end

  assign lxl = (lx_q == '0) ? COL_W'(1) : lx_q - COL_W'(1);
  assign lxr = ({1'b0, lx_q} == width_q - 13'd1) ? COL_W'(width_q - 13'd2) : lx_q + COL_W'(1);
  assign wr_addr = LS_AW'(slot_q) * LS_AW'(MAX_WIDTH) + LS_AW'(col_q);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IN:     if (row_end && row_q != '0) st_d = ST_LAP;
      ST_LAP: begin
        if (lap_end) begin
          priority if (second_q) st_d = ST_LAP;
          else if (fin_q) st_d = ST_V_RD;
          else st_d = ST_IN;
        end
      end
      ST_V_RD:   st_d = ST_V_LD;
      ST_V_LD:   st_d = ST_V_MA;
      ST_V_MA:   if (mul_done) st_d = ST_V_MB;
      ST_V_MB:   if (mul_done) st_d = ST_V_MC;
      ST_V_MC:   if (mul_done) st_d = ST_V_DIV;
      ST_V_DIV:  if (div_done) st_d = ST_V_CMP;
      ST_V_CMP:  st_d = (vk_q == CELL_W'(CELLS - 1)) ? ST_R_SEED : ST_V_RD;
      ST_R_SEED: begin
        priority if (map_q[rk_q] && !seen_q[rk_q]) st_d = ST_R_GROW;
        else if (rk_q == CELL_W'(CELLS - 1)) st_d = ST_DONE;
        else st_d = ST_R_SEED;
      end
      ST_R_GROW: if (grow_done) st_d = ST_R_SUM;
      ST_R_SUM:  st_d = (rk_q == CELL_W'(CELLS - 1)) ? ST_DONE : ST_R_SEED;
      ST_DONE:   if (!res_valid_q || result_ready_i) st_d = ST_IN;
      default:   st_d = ST_IN;
    endcase
  end

  always_comb begin
    pixel_ready_o = (st_q == ST_IN);
    cell_addr = (st_q == ST_LAP) ? k_cur : vk_q;
    unique case (ph_q)
      3'd0:    rd_addr = LS_AW'(up_q) * LS_AW'(MAX_WIDTH) + LS_AW'(lx_q);
      3'd1:    rd_addr = LS_AW'(dn_q) * LS_AW'(MAX_WIDTH) + LS_AW'(lx_q);
      3'd2:    rd_addr = LS_AW'(ctr_q) * LS_AW'(MAX_WIDTH) + LS_AW'(lxl);
      3'd3:    rd_addr = LS_AW'(ctr_q) * LS_AW'(MAX_WIDTH) + LS_AW'(lxr);
      default: rd_addr = LS_AW'(ctr_q) * LS_AW'(MAX_WIDTH) + LS_AW'(lx_q);
    endcase
  end

  always_comb begin
    rdx = signed'({4'b0, rd_q});
    ent = cell_vld_q ? cell_rd_q : '0;
    vsq = v_q * v_q;
    upd.sum = ent.sum + SUM_W'(v_q);
    upd.sq = ent.sq + SQ_W'(vsq[19:0]);
    upd.cnt = ent.cnt + CNT_W'(1);
    mag = (ent.sum < 0) ? SUM_W'(-ent.sum) : SUM_W'(ent.sum);
    mt = {1'b0, p_q[MP_W-1:ML_W]} + (p_q[0] ? {1'b0, mcand_q} : '0);
    p_next = {mt, p_q[ML_W-1:1]};
    r2 = {rem_q, dd_q[DD_W-1]};
    ge = (r2 >= (REM_W+1)'(dv_q));
    var_v = z_q ? '0 : (sat_q ? VAR_MAX : q_q);
    rsize = 4'($countones(rg_q));
    csz = cfg_data_i[SIZE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) mem[wr_addr] <= pixel_i;
    if (st_q == ST_LAP) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cell_rd_q <= cmem[cell_addr];
    cell_vld_q <= cvalid_q[cell_addr];
    if (st_q == ST_LAP && ph_q == 3'd6) cmem[k_cur] <= upd;
  end

  always_ff @(posedge clk_i) begin
    for (int j = 1; j < CELL_ROWS; j++) begin
      rb_q[j] <= SIZE_W'(((49'(j) * 49'(height_q)) * 49'(RECIP_R)) >> 32);
    end
    for (int j = 1; j < CELL_COLS; j++) begin
      cb_q[j] <= SIZE_W'(((49'(j) * 49'(width_q)) * 49'(RECIP_C)) >> 32);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IN;
      width_q <= 13'd640;
      height_q <= 13'd480;
      thresh_q <= 29'd25600;
      col_q <= '0;
      row_q <= '0;
      slot_q <= '0;
      lx_q <= '0;
      ph_q <= '0;
      second_q <= 1'b0;
      fin_q <= 1'b0;
      cvalid_q <= '0;
      cnt_q <= '0;
      vk_q <= '0;
      rk_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_valid_q && result_ready_i) res_valid_q <= 1'b0;
      if (acc_in) col_q <= row_end ? '0 : col_q + COL_W'(1);
      if (row_end) begin
        if (row_q == '0) begin
          row_q <= COL_W'(1);
          slot_q <= slot_p1;
        end else begin
          ctr_q <= slot_m1;
          dn_q <= slot_q;
          up_q <= (row_q == COL_W'(1)) ? slot_q : slot_p1;
          gr_q <= gr_prev;
          second_q <= last_row;
          fin_q <= last_row;
          lx_q <= '0;
          ph_q <= '0;
        end
      end
      if (st_q == ST_LAP) begin
        unique case (ph_q)
          3'd1:    acc_q <= rdx;
          3'd2, 3'd3, 3'd4: acc_q <= acc_q + rdx;
          3'd5:    v_q <= acc_q - (rdx <<< 2);
          default: ;
        endcase
        if (ph_q == 3'd6) begin
          ph_q <= '0;
          cvalid_q[k_cur] <= 1'b1;
          if (!lap_end) lx_q <= lx_q + COL_W'(1);
        end else begin
          ph_q <= ph_q + 3'd1;
        end
        if (lap_end) begin
          lx_q <= '0;
          priority if (second_q) begin
            second_q <= 1'b0;
            ctr_q <= slot_q;
            up_q <= slot_m1;
            dn_q <= slot_m1;
            gr_q <= gr_cur;
          end else if (fin_q) begin
            fin_q <= 1'b0;
            vk_q <= '0;
            minv_q <= VAR_MAX;
            map_q <= '0;
          end else begin
            row_q <= row_q + COL_W'(1);
            slot_q <= slot_p1;
          end
        end
      end
      unique case (st_q)
        ST_V_LD: begin
          n_q <= ent.cnt;
          mag_q <= mag;
          p_q <= MP_W'(ent.cnt);
          mcand_q <= ent.sq;
          cnt_q <= '0;
        end
        ST_V_MA, ST_V_MB, ST_V_MC: begin
          p_q <= p_next;
          cnt_q <= cnt_q + 7'd1;
          if (mul_done) begin
            cnt_q <= '0;
            if (st_q == ST_V_MA) begin
              a_q <= p_next;
              p_q <= MP_W'(mag_q);
              mcand_q <= MC_W'(mag_q);
            end else if (st_q == ST_V_MB) begin
              b_q <= p_next;
              p_q <= MP_W'(n_q);
              mcand_q <= MC_W'(n_q);
            end else begin
              dv_q <= DV_W'(p_next);
              z_q <= (n_q == '0) || (a_q <= b_q);
              dd_q <= {a_q - b_q, 8'b0};
              rem_q <= '0;
              q_q <= '0;
              sat_q <= 1'b0;
            end
          end
        end
        ST_V_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          dd_q <= dd_q << 1;
          rem_q <= ge ? REM_W'(r2 - (REM_W+1)'(dv_q)) : REM_W'(r2);
          q_q <= {q_q[VAR_W-2:0], ge};
          sat_q <= sat_q | q_q[VAR_W-1];
        end
        ST_V_CMP: begin
          if (var_v < minv_q) minv_q <= var_v;
          if (var_v < thresh_q) map_q[vk_q] <= 1'b1;
          vk_q <= vk_q + CELL_W'(1);
          rk_q <= '0;
          seen_q <= '0;
          best_q <= '0;
        end
        ST_R_SEED: begin
          cnt_q <= '0;
          rg_q <= CELLS'(1) << rk_q;
          if (!(map_q[rk_q] && !seen_q[rk_q])) rk_q <= rk_q + CELL_W'(1);
        end
        ST_R_GROW: begin
          rg_q <= grow(rg_q, map_q);
          cnt_q <= cnt_q + 7'd1;
        end
        ST_R_SUM: begin
          if (rsize > best_q) best_q <= rsize;
          seen_q <= seen_q | rg_q;
          rk_q <= rk_q + CELL_W'(1);
        end
        ST_DONE: begin
          if (!res_valid_q || result_ready_i) begin
            res_valid_q <= 1'b1;
            res_min_q <= minv_q;
            res_reg_q <= best_q;
            res_flag_q <= (best_q >= 4'd4);
            cvalid_q <= '0;
            col_q <= '0;
            row_q <= '0;
            slot_q <= '0;
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          IDX_WIDTH:  width_q <= (csz < 13'd4) ? 13'd4 :
                                 (csz > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : csz;
          IDX_HEIGHT: height_q <= (csz < 13'd4) ? 13'd4 :
                                  (csz > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : csz;
          IDX_THRESH: thresh_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (size_wr) begin
        cvalid_q <= '0;
        col_q <= '0;
        row_q <= '0;
        slot_q <= '0;
        second_q <= 1'b0;
        fin_q <= 1'b0;
        st_q <= ST_IN;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign var_min_o = res_min_q;
  assign largest_region_o = res_reg_q;
  assign large_blur_area_o = res_flag_q;

  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(st_q == ST_DONE))
    else $error("Result raised outside the frame end state.");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IN) |-> ({1'b0, col_q} < width_q))
    else $error("Column position ran past the row width.");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_LAP) |-> (ph_q <= 3'd6))
    else $error("Sweep phase out of range.");

  a_region_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (largest_region_o <= 4'(CELLS) &&
                        large_blur_area_o == (largest_region_o >= 4'd4)))
    else $error("Region size and flag disagree.");

endmodule
